// File: rtl/sdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdb_pkg
// Shared types and constants of the 3x3 star detector.
// ----------------------------------------------------------------------------
package sdb_pkg;

  localparam int unsigned PIX_W    = 5;
  localparam int unsigned WIDTH_W  = 8;
  localparam int unsigned HEIGHT_W = 7;
  localparam int unsigned THR_W    = 9;
  localparam int unsigned SUM_W    = 9;
  localparam int unsigned CROW_W   = 6;
  localparam int unsigned CCOL_W   = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam int unsigned DIM_MIN = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 8'd20;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd5;
  localparam logic [THR_W-1:0]    THR_RST    = 9'd90;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_THRESHOLD = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  // One line-buffer entry: the pixel two rows up and the pixel one row up
  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } lb_entry_t;

endpackage

// File: rtl/sdb_linebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdb_linebuf
// Dual line buffer as one synchronous memory, one write and one read port,
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module sdb_linebuf #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output sdb_pkg::lb_entry_t rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  sdb_pkg::lb_entry_t wr_data_i
);
  import sdb_pkg::*;

  lb_entry_t mem_q [DEPTH];
  lb_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read returns the old contents on an address collision
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/star_detect_box3x3_threshold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_detect_box3x3_threshold_core
// Streaming 3x3 box-sum star detector with a configurable sum threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the in_* valid/ready channel, one per
//   transfer; frame_start_i on a pixel places it at row 0, column 0.
//   For every pixel at row >= 2 and column >= 2 one result leaves on the
//   out_* channel: the window centre (row - 1, column - 1), the sum of the
//   nine intensities, a star flag (sum > threshold) and a last flag on the
//   final interior result of the frame. Edge positions produce no result.
//   Throughput: one pixel per cycle while the receiver takes results, set
//   by the line-buffer memory, which does one read and one write-back of
//   a column entry each cycle. A result passes the memory read stage, then
//   the output register. When the receiver stalls, the output register
//   and the read stage hold and in_ready_o drops once both are full;
//   nothing is lost. Reset clears counters, window and configuration to
//   their defaults; the line buffer needs no clearing pass, since entries
//   read in rows 0 and 1 feed no result. Write configuration only while
//   idle.
// ----------------------------------------------------------------------------
module star_detect_box3x3_threshold_core #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [sdb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sdb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sdb_pkg::PIX_W-1:0]       intensity_i,
  input  logic                            frame_start_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sdb_pkg::CROW_W-1:0]      center_row_o,
  output logic [sdb_pkg::CCOL_W-1:0]      center_col_o,
  output logic [sdb_pkg::SUM_W-1:0]       window_sum_o,
  output logic                            is_star_o,
  output logic                            last_o
);
  import sdb_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WXW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam int unsigned HXW = (RW + 1 > HEIGHT_W) ? RW + 1 : HEIGHT_W;
  localparam int unsigned CXW = (CW > CCOL_W) ? CW : CCOL_W;
  localparam int unsigned RXW = (RW > CROW_W) ? RW : CROW_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [THR_W-1:0]    thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thr_q    <= THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i[HEIGHT_W-1:0];
        CFG_SUM_THRESHOLD: thr_q    <= cfg_wdata_i[THR_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // Clamp the geometry to [3, MAX] and form the last column and row index
  logic [WXW-1:0] w_ext, w_clamp, w_last_full;
  logic [HXW-1:0] h_ext, h_clamp, h_last_full;
  logic [CW-1:0]  w_last;
  logic [RW-1:0]  h_last;

  always_comb begin
    w_ext = WXW'(width_q);
    if (w_ext < WXW'(DIM_MIN)) begin
      w_clamp = WXW'(DIM_MIN);
    end else if (w_ext > WXW'(MAX_WIDTH)) begin
      w_clamp = WXW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    w_last_full = w_clamp - WXW'(1);
    w_last      = w_last_full[CW-1:0];

    h_ext = HXW'(height_q);
    if (h_ext < HXW'(DIM_MIN)) begin
      h_clamp = HXW'(DIM_MIN);
    end else if (h_ext > HXW'(MAX_HEIGHT)) begin
      h_clamp = HXW'(MAX_HEIGHT);
    end else begin
      h_clamp = h_ext;
    end
    h_last_full = h_clamp - HXW'(1);
    h_last      = h_last_full[RW-1:0];
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_adv;
  logic in_xfer;
  logic out_valid_q;

  // The read stage moves on whenever the output register is free or drains
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Position counters (stage 0, at the input transfer)
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_eff;
  logic [RW-1:0] row_q, row_eff;
  logic          col_wrap, row_wrap;
  logic          emit_d, fin_d;
  logic [CXW-1:0] ccol_full;
  logic [RXW-1:0] crow_full;

  always_comb begin
    col_eff   = frame_start_i ? '0 : col_q;
    row_eff   = frame_start_i ? '0 : row_q;
    col_wrap  = col_eff >= w_last;
    row_wrap  = row_eff >= h_last;
    emit_d    = (row_eff >= RW'(2)) && (col_eff >= CW'(2));
    fin_d     = row_wrap && col_wrap;
    ccol_full = CXW'(col_eff) - CXW'(1);
    crow_full = RXW'(row_eff) - RXW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_eff + RW'(1);
      end else begin
        col_q <= col_eff + CW'(1);
        row_q <= row_eff;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pixel waits here while its column entry is read
  // --------------------------------------------------------------------------
  pix_t              s1_pix_q;
  logic [CW-1:0]     s1_col_q;
  logic [CROW_W-1:0] s1_crow_q;
  logic [CCOL_W-1:0] s1_ccol_q;
  logic              s1_emit_q;
  logic              s1_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q  <= intensity_i;
      s1_col_q  <= col_eff;
      s1_crow_q <= crow_full[CROW_W-1:0];
      s1_ccol_q <= ccol_full[CCOL_W-1:0];
      s1_emit_q <= emit_d;
      s1_fin_q  <= fin_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer: read at the transfer, write back when stage 1 advances
  // --------------------------------------------------------------------------
  lb_entry_t rd_data, wr_data, fwd_data_q;
  logic      fwd_q;
  pix_t      top, mid;

  sdb_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_eff),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data)
  );

  // A frame restart can read the column that is being written back in the
  // same cycle; capture the written entry and bypass the stale read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_xfer) begin
      fwd_q <= s1_adv && (s1_col_q == col_eff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fwd_data_q <= wr_data;
    end
  end

  always_comb begin
    top           = fwd_q ? fwd_data_q.upper : rd_data.upper;
    mid           = fwd_q ? fwd_data_q.lower : rd_data.lower;
    // shift the column down: the row above becomes two above
    wr_data.upper = mid;
    wr_data.lower = s1_pix_q;
  end

  // --------------------------------------------------------------------------
  // 3x3 window: columns 0..2 old to new, rows 0..2 top to bottom
  // --------------------------------------------------------------------------
  pix_t win_q [3][3];
  pix_t new_col [3];
  logic [SUM_W-1:0] sum_d;

  always_comb begin
    new_col[0] = top;
    new_col[1] = mid;
    new_col[2] = s1_pix_q;
    sum_d = '0;
    for (int r = 0; r < 3; r++) begin
      sum_d = sum_d + SUM_W'(win_q[r][1]) + SUM_W'(win_q[r][2]) + SUM_W'(new_col[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
        win_q[r][2] <= new_col[r];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [CROW_W-1:0] crow_q;
  logic [CCOL_W-1:0] ccol_q;
  logic [SUM_W-1:0]  sum_q;
  logic              star_q;
  logic              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_emit_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      crow_q <= s1_crow_q;
      ccol_q <= s1_ccol_q;
      sum_q  <= sum_d;
      star_q <= sum_d > thr_q;
      last_q <= s1_fin_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign center_row_o = crow_q;
  assign center_col_o = ccol_q;
  assign window_sum_o = sum_q;
  assign is_star_o    = star_q;
  assign last_o       = last_q;

endmodule

// File: tb/tb_star_detect_box3x3_threshold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_star_detect_box3x3_threshold_core
// Self-checking bench for the streaming 3x3 box-sum star detector.
// A pixel queue feeds a valid/ready driver. Every accepted pixel runs through
// a local copy of the detector, which queues the window result it expects.
// A monitor checks each output transfer against the oldest queued result.
// Geometry and threshold change between phases, only while the core is idle.
// Both sides idle at random, and in up to two phases the receiver holds off
// long enough to back the core up.
// ----------------------------------------------------------------------------
module tb_star_detect_box3x3_threshold_core;
  import sdb_pkg::*;

  localparam int unsigned MAX_W = 128;
  localparam int unsigned MAX_H = 64;
  // Index past the last register: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned LONG_HOLD    = 300;

  typedef struct packed {
    pix_t intensity;
    logic frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [CROW_W-1:0] row;
    logic [CCOL_W-1:0] col;
    logic [SUM_W-1:0]  win_sum;
    logic              star;
    logic              last;
  } window_res_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  pix_t                  intensity_i = '0;
  logic                  frame_start_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CROW_W-1:0]     center_row_o;
  logic [CCOL_W-1:0]     center_col_o;
  logic [SUM_W-1:0]      window_sum_o;
  logic                  is_star_o;
  logic                  last_o;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  star_detect_box3x3_threshold_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .intensity_i  (intensity_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .center_row_o (center_row_o),
    .center_col_o (center_col_o),
    .window_sum_o (window_sum_o),
    .is_star_o    (is_star_o),
    .last_o       (last_o)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  pixel_item_t pixel_q[$];          // pixels waiting to be offered
  window_res_t pending_windows[$];  // window results predicted, not yet seen
  int unsigned mismatch_cnt = 0;
  int unsigned items_queued = 0;
  bit          px_taken = 1'b0;     // set at the edge that completes a transfer
  bit          tx_idle_on = 1'b1;   // sender inserts gaps
  bit          rx_stall_on = 1'b1;  // receiver drops ready at random
  int unsigned hold_req = 0;        // bumped to ask the receiver for a long hold

  // Shadow of the configuration registers
  logic [WIDTH_W-1:0]  cfg_width  = WIDTH_RST;
  logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RST;
  logic [THR_W-1:0]    cfg_thr    = THR_RST;

  // Local detector state: two line buffers, the 3x3 window, raster position.
  // The _ok flags track which line-buffer entries hold real pixel data.
  pix_t        lb_top [MAX_W];
  pix_t        lb_mid [MAX_W];
  bit          lb_top_ok [MAX_W];
  bit          lb_mid_ok [MAX_W];
  pix_t        win [3][3];          // [top..bottom][old..new column]
  int unsigned row_cnt = 0;
  int unsigned col_cnt = 0;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the detector by one pixel and queue the window result, if any.
  task automatic detector_step(input pixel_item_t px);
    int unsigned w;
    int unsigned h;
    int unsigned acc;
    pix_t        top;
    pix_t        mid;
    window_res_t res;
    w = clamp_dim(cfg_width, MAX_W);
    h = clamp_dim(cfg_height, MAX_H);
    top = '0;
    mid = '0;
    if (px.frame_start) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    // Read the column entry, then push it one row up and store the new pixel
    if (col_cnt < MAX_W) begin
      top = lb_top[col_cnt];
      mid = lb_mid[col_cnt];
      lb_top[col_cnt]    = mid;
      lb_top_ok[col_cnt] = lb_mid_ok[col_cnt];
      lb_mid[col_cnt]    = px.intensity;
      lb_mid_ok[col_cnt] = 1'b1;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px.intensity;
    // Full window present only from row 2, column 2 on
    if (row_cnt >= 2 && col_cnt >= 2) begin
      acc = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          acc += win[r][c];
      res.row     = CROW_W'(row_cnt - 1);
      res.col     = CCOL_W'(col_cnt - 1);
      res.win_sum = SUM_W'(acc);
      res.star    = (acc > cfg_thr);
      res.last    = (row_cnt >= h - 1) && (col_cnt >= w - 1);
      pending_windows.push_back(res);
    end
    // Wrap at the last column; a counter past a shrunken geometry wraps too
    if (col_cnt >= w - 1) begin
      col_cnt = 0;
      if (row_cnt >= h - 1) row_cnt = 0;
      else row_cnt++;
    end else begin
      col_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: sample the transfer at the rising edge, drive at the falling edge
  // --------------------------------------------------------------------------
  int unsigned tx_gap_left = 0;

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned tx_gap();
    int unsigned r;
    if (!tx_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      detector_step('{intensity: intensity_i, frame_start: frame_start_i});
      px_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : pixel_driver
    pixel_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || px_taken) begin
      // Slot is free: idle out the gap or present the next pixel
      px_taken = 1'b0;
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        nxt = pixel_q.pop_front();
        in_valid_i    <= 1'b1;
        intensity_i   <= nxt.intensity;
        frame_start_i <= nxt.frame_start;
        tx_gap_left = tx_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    // Otherwise hold valid and payload until the transfer happens
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern plus an occasional long hold-off
  // --------------------------------------------------------------------------
  int unsigned rx_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_done = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (hold_req != hold_done) begin
      // Hold ready low long enough for the core to fill and drop in_ready_o
      hold_done++;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (rx_left > 0) begin
      rx_left--;
    end else if (!rx_stall_on || $urandom_range(0, 1) == 1) begin
      out_ready_i <= 1'b1;
      rx_left = $urandom_range(0, 15);
    end else begin
      out_ready_i <= 1'b0;
      rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : window_monitor
    window_res_t got;
    window_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{row: center_row_o, col: center_col_o, win_sum: window_sum_o,
              star: is_star_o, last: last_o};
      if (pending_windows.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected result row %0d col %0d sum %0d star %0b last %0b",
                   $realtime, got.row, got.col, got.win_sum, got.star, got.last);
      end else begin
        want = pending_windows.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.win_sum !== want.win_sum ||
            got.star !== want.star || got.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"%0t: mismatch exp row %0d col %0d sum %0d star %0b last %0b,",
                      " got row %0d col %0d sum %0d star %0b last %0b"},
                     $realtime, want.row, want.col, want.win_sum, want.star, want.last,
                     got.row, got.col, got.win_sum, got.star, got.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Wait until every pixel went in and every result came out, then let the
  // pipeline settle, since the last pixels may have produced no result.
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid_i || pending_windows.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:   cfg_width  = data[WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT:  cfg_height = data[HEIGHT_W-1:0];
      CFG_SUM_THRESHOLD: cfg_thr    = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned thr);
    wait_drained();
    cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_write(CFG_SUM_THRESHOLD, CFG_DATA_W'(thr));
  endtask

  // Any column in use that does not hold two real rows yet? Then the next
  // phase has to restart the frame so that rows 0 and 1 refill it.
  function automatic bit needs_restart(input int unsigned w);
    for (int unsigned c = 0; c < w; c++)
      if (!lb_top_ok[c] || !lb_mid_ok[c]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic pix_t next_intensity(input int unsigned mode);
    case (mode)
      0: return pix_t'($urandom_range(0, 31));
      1: return ($urandom_range(0, 9) != 0) ? pix_t'($urandom_range(0, 6))
                                            : pix_t'($urandom_range(20, 31));
      2: return ($urandom_range(0, 1) == 1) ? pix_t'(31) : pix_t'(0);
      default: return pix_t'($urandom_range(8, 24));
    endcase
  endfunction

  // Queue one raster frame of w x h pixels, cut short after len pixels
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit fs,
                             input int unsigned len, input int unsigned mode);
    int unsigned n;
    n = (len < w * h) ? len : w * h;
    for (int unsigned i = 0; i < n; i++) begin
      pixel_q.push_back('{intensity: next_intensity(mode), frame_start: fs && (i == 0)});
      items_queued++;
    end
  endtask

  task automatic queue_pixel(input int unsigned value, input bit fs);
    pixel_q.push_back('{intensity: pix_t'(value), frame_start: fs});
  endtask

  int unsigned sp_w [7] = '{20, 128, 255, 3, 0, 2, 3};
  int unsigned sp_h [7] = '{5, 3, 4, 64, 127, 1, 3};
  int unsigned sp_t [7] = '{90, 279, 511, 0, 140, 200, 511};

  initial begin : stimulus
    int unsigned p;
    int unsigned w;
    int unsigned h;
    int unsigned thr;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned npix;
    int unsigned nfr;
    int unsigned len;
    bit          force_fs;
    bit          fs;

    for (int i = 0; i < MAX_W; i++) begin
      lb_top[i] = '0;
      lb_mid[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all-bright window just above and at the threshold, then a
    // frame that wraps without frame_start, then noise cut off by a restart.
    set_geometry(3, 3, 278);
    for (int i = 0; i < 9; i++) queue_pixel(31, i == 0);
    set_geometry(3, 3, 279);
    for (int i = 0; i < 9; i++) queue_pixel(31, 1'b0);
    set_geometry(3, 3, 0);
    queue_pixel(5, 1'b1);
    queue_pixel(7, 1'b0);
    for (int i = 0; i < 9; i++) queue_pixel((i == 4) ? 1 : 0, i == 0);
    wait_drained();
    cfg_write(CFG_NO_REG, '1);

    // Random phases: special geometries first, then mostly small frames
    items_queued = 0;
    p = 0;
    while (items_queued < RANDOM_ITEMS) begin
      if (p < 7) begin
        w = sp_w[p];
        h = sp_h[p];
        thr = sp_t[p];
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:84]: begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 6);
          end
          [85:96]: begin
            w = $urandom_range(13, 40);
            h = $urandom_range(3, 8);
          end
          default: begin
            w = $urandom_range(41, 128);
            h = 3;
          end
        endcase
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: thr = 0;
            1: thr = 279;
            2: thr = 511;
            default: thr = $urandom_range(280, 511);
          endcase
        end else begin
          thr = $urandom_range(60, 220);
        end
        // Bits above the register width must be ignored
        if ($urandom_range(0, 6) == 0) begin
          w = w | 9'h100;
          h = h | ($urandom_range(1, 3) << 7);
        end
        tx_idle_on  = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
      end
      set_geometry(w, h, thr);
      // Phase 3 is a narrow tall frame: results start within a few pixels, so the
      // hold backs the core up while the sender keeps offering; phase 15 holds too
      if (p == 3 || p == 15) hold_req++;

      w_eff = clamp_dim(cfg_width, MAX_W);
      h_eff = clamp_dim(cfg_height, MAX_H);
      npix  = w_eff * h_eff;
      nfr   = (npix > 200) ? 1 : $urandom_range(1, 4);
      force_fs = needs_restart(w_eff);
      for (int unsigned f = 0; f < nfr; f++) begin
        if (f == 0) fs = force_fs || ($urandom_range(0, 9) != 0);
        else fs = ($urandom_range(0, 3) != 0);
        // Now and then a frame broken off early
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, npix - 1) : npix;
        queue_frame(w_eff, h_eff, fs, len, $urandom_range(0, 3));
      end
      p++;
    end

    // Let the last results out, then give any stray output time to show up
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_windows.size() == 0) begin
      $display("star_detect_box3x3_threshold_core test passed");
    end else begin
      $display("star_detect_box3x3_threshold_core test failed");
    end
    $finish;
  end

  // Hard stop in case the core hangs
  initial begin
    #4000000;
    $display("star_detect_box3x3_threshold_core test failed");
    $finish;
  end

endmodule

// File: star_detect_box3x3_threshold_core.f
rtl/sdb_pkg.sv
rtl/sdb_linebuf.sv
rtl/star_detect_box3x3_threshold_core.sv
tb/tb_star_detect_box3x3_threshold_core.sv
